/* src/wpm_pkg.sv */
package wpm_pkg;

    // Pattern store geometry
    localparam int MAX_PATTERN = 64;
    localparam int ADDR_W      = $clog2(MAX_PATTERN);
    localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
    localparam int SYM_W       = 8;

    // Special pattern symbols
    localparam logic [SYM_W-1:0] SYM_STAR = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_ANY  = 8'h3F;

    // Operation codes carried in tuser
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_START  = 2'd2,
        OP_TEXT   = 2'd3
    } t_op;

    // Controller to datapath commands
    typedef struct packed {
        logic take;         // latch symbol and overflow flag of the transaction
        logic flag_ovf;     // append dropped because the store is full
        logic clear_cnt;    // pattern length to zero
        logic append;       // write symbol at the end of the pattern
        logic begin_empty;  // start an empty-text column pass
        logic begin_text;   // start a text-byte column pass
        logic prime;        // issue the first pattern read
        logic step;         // update one prefix bit
        logic load_out;     // capture the result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic full;         // pattern store is full
        logic cnt_zero;     // pattern is empty
        logic last;         // current prefix is the whole pattern
    } t_sts;

endpackage

/* src/wildcard_pattern_match.sv */
// Channel  Direction  Signals                        Contents
// s_axis   in         tvalid tready tdata[7:0]       tdata: symbol
//                     tuser[1:0]                     tuser: operation
// m_axis   out        tvalid tready tdata[7:0]       tdata: matched, overflow, zeros
//
// A clear, a full-store append, or a start or text byte with an empty pattern goes straight to finish.
// Other items prime a pattern read, then step through every prefix of the pattern (after the append):
// the column is walked one prefix bit per cycle, each step reading one pattern byte.
// Reset is synchronous and active low; the pattern store keeps no reset value.
// A finished result waits in the output register; the next item is accepted while it
// waits, and only the next result holds until the output side takes the previous one.
module wildcard_pattern_match (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [7:0]                i_s_axis_tdata,   // [7:0] symbol
    input  logic [1:0]                i_s_axis_tuser,   // [1:0] operation
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [7:0]                o_m_axis_tdata    // [0] matched, [1] overflow
);
    import wpm_pkg::*;

    t_cmd cmd;
    t_sts sts;
    t_op  op;
    logic matched;
    logic overflow;

    assign op = t_op'(i_s_axis_tuser);

    wpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_op        (op),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (sts),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (cmd)
    );

    wpm_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_symbol   (i_s_axis_tdata),
        .o_sts      (sts),
        .o_matched  (matched),
        .o_overflow (overflow)
    );

    // Pack the result
    assign o_m_axis_tdata = {6'b0, overflow, matched};

endmodule

/* src/wpm_ram.sv */
module wpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/wpm_datapath.sv */
module wpm_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  wpm_pkg::t_cmd              i_cmd,
    input  logic [wpm_pkg::SYM_W-1:0]  i_symbol,
    output wpm_pkg::t_sts              o_sts,
    output logic                       o_matched,
    output logic                       o_overflow
);
    import wpm_pkg::*;

    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic [MAX_PATTERN:0] r_bits, n_bits;
    logic                 r_diag, n_diag;
    logic                 r_prev, n_prev;
    logic                 r_text, n_text;
    logic [SYM_W-1:0]     r_sym, n_sym;
    logic                 r_ovf, n_ovf;
    logic                 r_matched, n_matched;
    logic                 r_ovf_out, n_ovf_out;

    logic [SYM_W-1:0]     pat;
    logic [CNT_W-1:0]     rd_ptr;
    logic                 old_bit;
    logic                 new_bit;
    logic                 is_star;

    // Pattern store
    assign rd_ptr = i_cmd.prime ? (r_idx - CNT_W'(1)) : r_idx;

    wpm_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_PATTERN)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.append),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_symbol),
        .i_raddr (rd_ptr[ADDR_W-1:0]),
        .o_rdata (pat)
    );

    // One prefix bit of the column
    assign is_star = (pat == SYM_STAR);
    assign old_bit = r_bits[r_idx];

    always_comb begin
        if (r_text) begin
            if (is_star) begin
                new_bit = old_bit | r_prev;
            end else if (pat == SYM_ANY || pat == r_sym) begin
                new_bit = r_diag;
            end else begin
                new_bit = 1'b0;
            end
        end else begin
            new_bit = r_prev & is_star;
        end
    end

    // Next-state logic
    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_bits    = r_bits;
        n_diag    = r_diag;
        n_prev    = r_prev;
        n_text    = r_text;
        n_sym     = r_sym;
        n_ovf     = r_ovf;
        n_matched = r_matched;
        n_ovf_out = r_ovf_out;

        if (i_cmd.take) begin
            n_sym = i_symbol;
            n_ovf = i_cmd.flag_ovf;
        end
        if (i_cmd.clear_cnt) begin
            n_count = '0;
        end
        if (i_cmd.append) begin
            n_count = r_count + CNT_W'(1);
        end
        if (i_cmd.begin_empty) begin
            n_bits    = '0;
            n_bits[0] = 1'b1;
            n_prev    = 1'b1;
            n_text    = 1'b0;
            n_idx     = CNT_W'(1);
        end
        if (i_cmd.begin_text) begin
            n_diag    = r_bits[0];
            n_bits[0] = 1'b0;
            n_prev    = 1'b0;
            n_text    = 1'b1;
            n_idx     = CNT_W'(1);
        end
        if (i_cmd.step) begin
            n_bits[r_idx] = new_bit;
            n_diag        = old_bit;
            n_prev        = new_bit;
            n_idx         = r_idx + CNT_W'(1);
        end
        if (i_cmd.load_out) begin
            n_matched = r_bits[r_count];
            n_ovf_out = r_ovf;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_idx     <= '0;
            r_bits    <= (MAX_PATTERN + 1)'(1);
            r_text    <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_bits    <= n_bits;
            r_text    <= n_text;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_diag    <= n_diag;
        r_prev    <= n_prev;
        r_sym     <= n_sym;
        r_ovf     <= n_ovf;
        r_matched <= n_matched;
        r_ovf_out <= n_ovf_out;
    end

    assign o_sts.full     = (r_count == CNT_W'(MAX_PATTERN));
    assign o_sts.cnt_zero = (r_count == '0);
    assign o_sts.last     = (r_idx == r_count);
    assign o_matched      = r_matched;
    assign o_overflow     = r_ovf_out;

endmodule

/* src/wpm_ctrl.sv */
module wpm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  wpm_pkg::t_op   i_op,
    input  logic           i_out_ready,
    input  wpm_pkg::t_sts  i_sts,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output wpm_pkg::t_cmd  o_cmd
);
    import wpm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PRIME,
        S_STEP,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   out_free;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    // Decode commands and next state
    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.take = 1'b1;
                    case (i_op)
                        OP_CLEAR: begin
                            o_cmd.clear_cnt   = 1'b1;
                            o_cmd.begin_empty = 1'b1;
                            n_state           = S_FINISH;
                        end
                        OP_APPEND: begin
                            if (i_sts.full) begin
                                o_cmd.flag_ovf = 1'b1;
                                n_state        = S_FINISH;
                            end else begin
                                o_cmd.append      = 1'b1;
                                o_cmd.begin_empty = 1'b1;
                                n_state           = S_PRIME;
                            end
                        end
                        OP_START: begin
                            o_cmd.begin_empty = 1'b1;
                            n_state = i_sts.cnt_zero ? S_FINISH : S_PRIME;
                        end
                        default: begin
                            o_cmd.begin_text = 1'b1;
                            n_state = i_sts.cnt_zero ? S_FINISH : S_PRIME;
                        end
                    endcase
                end
            end
            S_PRIME: begin
                o_cmd.prime = 1'b1;
                n_state     = S_STEP;
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                if (i_sts.last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // Hold here while the previous result is still waiting
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* src/wpm_checker.sv */
module wpm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic [1:0] i_s_axis_tuser,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata
);
    import wpm_pkg::*;

    // Busy after taking a transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken while a transaction is in progress");

    // Stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // Clear with a free output reports a match and no overflow once the finish state loads the result
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == OP_CLEAR
            && !o_m_axis_tvalid
        |-> ##2 o_m_axis_tvalid && o_m_axis_tdata[0] && !o_m_axis_tdata[1])
        else $error("clear did not report an empty match");

    // Padding bits stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[7:2] == 6'b0)
        else $error("result padding not zero");

endmodule

bind wildcard_pattern_match wpm_checker u_wpm_checker (.*);
